// File: rtl/mfpp_pkg.sv
// Shared constants and the index-use function of the motion-capture frame packet parser.
// Depends on nothing; used by mfpp_walker, the parser unit and the testbench.
package mfpp_pkg;

    localparam logic [5:0] PH_IDLE   = 6'd63;
    localparam logic [5:0] CODE_ERR  = 6'd37;
    localparam logic [5:0] CODE_PRM  = 6'd35;
    localparam logic [5:0] CODE_END  = 6'd36;
    localparam logic [7:0] MODEL_UPDATE_MASK = 8'h02;
    localparam logic [7:0] DEVICE_MINOR = 8'd11;
    localparam int         QDEPTH    = 4;
    localparam logic [1:0] REG_MAJOR = 2'd0;
    localparam logic [1:0] REG_MINOR = 2'd1;

    // Index use per code: bits 1:0 loop indices used, bit 2 word index used
    function automatic logic [2:0] index_use(input logic [5:0] code);
        logic [2:0] u;
        u = 3'd0;
        case (code)
            6'd2, 6'd3, 6'd9, 6'd11, 6'd12, 6'd17, 6'd18,
            6'd20, 6'd21, 6'd25, 6'd26: u = 3'd1;
            6'd14, 6'd22, 6'd27:        u = 3'd2;
            6'd23, 6'd28:               u = 3'd3;
            6'd4, 6'd13:                u = 3'd6;
            6'd6, 6'd8, 6'd16:          u = 3'd5;
            6'd30:                      u = 3'd4;
            default:                    u = 3'd0;
        endcase
        return u;
    endfunction

endpackage

// File: rtl/mfpp_walker.sv
// Layout walker: tracks the parse phase, byte collection, loop counters and
// builds one result per completed field. Depends on mfpp_pkg.
module mfpp_walker #(
    parameter int INDEX_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_major,
    input  logic [7:0]  i_minor,
    input  logic        i_valid,
    input  logic [7:0]  i_byte,
    input  logic        i_start,
    output logic        o_res_valid,
    output logic [5:0]  o_code,
    output logic [63:0] o_value,
    output logic [15:0] o_outer,
    output logic [15:0] o_inner,
    output logic [15:0] o_item,
    output logic [3:0]  o_word,
    output logic        o_end,
    output logic        o_models
);
    localparam int CW = INDEX_WIDTH + 1;

    logic [5:0]    r_phase, n_phase;
    logic [3:0]    r_pos, n_pos;
    logic [63:0]   r_acc, n_acc;
    logic [CW-1:0] r_ocnt, n_ocnt, r_icnt, n_icnt, r_tcnt, n_tcnt;
    logic [CW-1:0] r_lp0, n_lp0, r_lp1, n_lp1, r_lp2, n_lp2;
    logic [3:0]    r_word, n_word;

    logic          al1, al3, al6, al7, al9, al11, maj3;
    logic [3:0]    flen;
    logic [63:0]   v;
    logic [31:0]   cnt;
    logic          cnt_ok;
    logic [CW-1:0] cntn, lp0i, lp1i, lp2i;
    logic [2:0]    use_bits;
    logic [5:0]    nx_bodies, nx_skel, nx_lab, nx_plates, nx_dev;

    function automatic logic ge(input logic [7:0] mj, input logic [7:0] mn,
                                input logic [7:0] b);
        return (mj > 8'd2) || (mj == 8'd2 && mn >= b);
    endfunction

    always_comb begin
        al1  = ge(i_major, i_minor, 8'd1);
        al3  = ge(i_major, i_minor, 8'd3);
        al6  = ge(i_major, i_minor, 8'd6);
        al7  = ge(i_major, i_minor, 8'd7);
        al9  = ge(i_major, i_minor, 8'd9);
        al11 = ge(i_major, i_minor, mfpp_pkg::DEVICE_MINOR);
        maj3 = i_major >= 8'd3;
        nx_dev    = maj3 ? 6'd30 : 6'd29;
        nx_plates = al11 ? 6'd24 : nx_dev;
        nx_lab    = al9 ? 6'd19 : nx_plates;
        nx_skel   = al3 ? 6'd15 : nx_lab;
        nx_bodies = al1 ? 6'd10 : nx_skel;
    end

    // Field length of the current phase
    always_comb begin
        case (r_phase)
            6'd2:                          flen = 4'd1;
            6'd9, 6'd14, 6'd17, 6'd35:     flen = 4'd2;
            6'd31:                         flen = al7 ? 4'd8 : 4'd4;
            6'd32, 6'd33, 6'd34:           flen = 4'd8;
            default:                       flen = 4'd4;
        endcase
    end

    always_comb begin
        v = r_acc | ({56'd0, i_byte} << {r_pos[2:0], 3'b000});
        cnt = v[31] ? 32'd0 : v[31:0];
        cnt_ok = (cnt >> INDEX_WIDTH) == 32'd0 ||
                 cnt == (32'd1 << INDEX_WIDTH);
        cntn = CW'(cnt);
        lp0i = r_lp0 + 1'b1;
        lp1i = r_lp1 + 1'b1;
        lp2i = r_lp2 + 1'b1;
        use_bits = mfpp_pkg::index_use(r_phase);
    end

    always_comb begin
        n_phase = r_phase; n_pos = r_pos; n_acc = r_acc; n_word = r_word;
        n_ocnt = r_ocnt; n_icnt = r_icnt; n_tcnt = r_tcnt;
        n_lp0 = r_lp0; n_lp1 = r_lp1; n_lp2 = r_lp2;
        o_res_valid = 1'b0;
        o_code = r_phase; o_value = v;
        o_outer = '0; o_inner = '0; o_item = '0; o_word = '0;
        o_end = 1'b0; o_models = 1'b0;
        if (i_valid && i_start) begin
            n_phase = 6'd0; n_word = '0; n_pos = 4'd1; n_acc = {56'd0, i_byte};
            n_ocnt = '0; n_icnt = '0; n_tcnt = '0;
            n_lp0 = '0; n_lp1 = '0; n_lp2 = '0;
            if (r_phase != mfpp_pkg::PH_IDLE) begin
                o_res_valid = 1'b1; o_code = mfpp_pkg::CODE_ERR;
                o_value = '0; o_end = 1'b1;
            end
        end else if (i_valid && r_phase != mfpp_pkg::PH_IDLE) begin
            n_acc = v; n_pos = r_pos + 4'd1;
            if (n_pos >= flen) begin
                n_acc = '0; n_pos = '0;
                o_res_valid = 1'b1;
                if (use_bits[1:0] >= 2'd1) o_outer = 16'(r_lp0);
                if (use_bits[1:0] >= 2'd2) o_inner = 16'(r_lp1);
                if (use_bits[1:0] == 2'd3) o_item  = 16'(r_lp2);
                if (use_bits[2]) o_word = r_word;
                o_end = r_phase == mfpp_pkg::CODE_END;
                o_models = r_phase == mfpp_pkg::CODE_PRM &&
                           (v[7:0] & mfpp_pkg::MODEL_UPDATE_MASK) != 8'd0;
                case (r_phase)
                    6'd0: n_phase = 6'd1;
                    6'd1, 6'd5, 6'd7, 6'd10, 6'd15, 6'd19, 6'd24: begin
                        n_ocnt = cntn; n_lp0 = '0;
                        if (cntn == '0) begin
                            case (r_phase)
                                6'd1:  n_phase = 6'd5;
                                6'd5:  n_phase = 6'd7;
                                6'd7:  n_phase = nx_bodies;
                                6'd10: n_phase = nx_skel;
                                6'd15: n_phase = nx_lab;
                                6'd19: n_phase = nx_plates;
                                default: n_phase = nx_dev;
                            endcase
                        end else begin
                            case (r_phase)
                                6'd1:  n_phase = 6'd2;
                                6'd5:  n_phase = 6'd6;
                                default: n_phase = r_phase + 6'd1;
                            endcase
                        end
                    end
                    6'd2: if (v == 64'd0) n_phase = 6'd3;
                    6'd3, 6'd12, 6'd21, 6'd26: begin
                        n_icnt = cntn; n_lp1 = '0;
                        if (cntn == '0) begin
                            n_lp0 = lp0i;
                            case (r_phase)
                                6'd3:  n_phase = lp0i >= r_ocnt ? 6'd5 : 6'd2;
                                6'd12: n_phase = lp0i >= r_ocnt ? nx_skel : 6'd11;
                                6'd21: n_phase = lp0i >= r_ocnt ? nx_plates : 6'd20;
                                default: n_phase = lp0i >= r_ocnt ? nx_dev : 6'd25;
                            endcase
                        end else n_phase = r_phase + 6'd1;
                    end
                    6'd4: begin
                        n_word = r_word + 4'd1;
                        if (n_word >= 4'd3) begin
                            n_word = '0; n_lp1 = lp1i;
                            if (lp1i >= r_icnt) begin
                                n_lp0 = lp0i;
                                n_phase = lp0i >= r_ocnt ? 6'd5 : 6'd2;
                            end
                        end
                    end
                    6'd6: begin
                        n_word = r_word + 4'd1;
                        if (n_word >= 4'd3) begin
                            n_word = '0; n_lp0 = lp0i;
                            if (lp0i >= r_ocnt) n_phase = 6'd7;
                        end
                    end
                    6'd8, 6'd13: begin
                        n_word = r_word + 4'd1;
                        if (n_word >= ((i_major >= 8'd2) ? 4'd9 : 4'd8)) begin
                            n_word = '0;
                            if (al6) n_phase = r_phase + 6'd1;
                            else if (r_phase == 6'd8) begin
                                n_lp0 = lp0i;
                                n_phase = lp0i >= r_ocnt ? nx_bodies : 6'd8;
                            end else begin
                                n_lp1 = lp1i;
                                if (lp1i >= r_icnt) begin
                                    n_lp0 = lp0i;
                                    n_phase = lp0i >= r_ocnt ? nx_skel : 6'd11;
                                end
                            end
                        end
                    end
                    6'd9: begin
                        n_lp0 = lp0i; n_phase = lp0i >= r_ocnt ? nx_bodies : 6'd8;
                    end
                    6'd14: begin
                        n_lp1 = lp1i;
                        if (lp1i >= r_icnt) begin
                            n_lp0 = lp0i;
                            n_phase = lp0i >= r_ocnt ? nx_skel : 6'd11;
                        end else n_phase = 6'd13;
                    end
                    6'd11, 6'd20, 6'd25, 6'd29: n_phase = r_phase + 6'd1;
                    6'd16: begin
                        n_word = r_word + 4'd1;
                        if (n_word >= 4'd5) begin
                            n_word = '0;
                            if (al6) n_phase = 6'd17;
                            else if (maj3) n_phase = 6'd18;
                            else begin
                                n_lp0 = lp0i;
                                n_phase = lp0i >= r_ocnt ? nx_lab : 6'd16;
                            end
                        end
                    end
                    6'd17, 6'd18: begin
                        if (r_phase == 6'd17 && maj3) n_phase = 6'd18;
                        else begin
                            n_lp0 = lp0i;
                            n_phase = lp0i >= r_ocnt ? nx_lab : 6'd16;
                        end
                    end
                    6'd22, 6'd27: begin
                        n_tcnt = cntn; n_lp2 = '0;
                        if (cntn == '0) begin
                            n_lp1 = lp1i;
                            if (lp1i >= r_icnt) begin
                                n_lp0 = lp0i;
                                if (lp0i >= r_ocnt)
                                    n_phase = r_phase == 6'd22 ? nx_plates : nx_dev;
                                else n_phase = r_phase - 6'd2;
                            end
                        end else n_phase = r_phase + 6'd1;
                    end
                    6'd23, 6'd28: begin
                        n_lp2 = lp2i;
                        if (lp2i >= r_tcnt) begin
                            n_lp1 = lp1i;
                            if (lp1i >= r_icnt) begin
                                n_lp0 = lp0i;
                                if (lp0i >= r_ocnt)
                                    n_phase = r_phase == 6'd23 ? nx_plates : nx_dev;
                                else n_phase = r_phase - 6'd3;
                            end else n_phase = r_phase - 6'd1;
                        end
                    end
                    6'd30: begin
                        if (r_word == 4'd0) n_word = 4'd1;
                        else begin n_word = '0; n_phase = 6'd31; end
                    end
                    6'd31: n_phase = maj3 ? 6'd32 : 6'd35;
                    6'd32, 6'd33, 6'd34, 6'd35: n_phase = r_phase + 6'd1;
                    default: n_phase = mfpp_pkg::PH_IDLE;
                endcase
                // word is cleared on every phase change
                if (n_phase != r_phase) n_word = '0;
                // oversized count turns the result into an error
                if ((r_phase == 6'd1 || r_phase == 6'd3 || r_phase == 6'd5 ||
                     r_phase == 6'd7 || r_phase == 6'd10 || r_phase == 6'd12 ||
                     r_phase == 6'd15 || r_phase == 6'd19 || r_phase == 6'd21 ||
                     r_phase == 6'd22 || r_phase == 6'd24 || r_phase == 6'd26 ||
                     r_phase == 6'd27) && !cnt_ok) begin
                    n_phase = mfpp_pkg::PH_IDLE; n_word = '0;
                    n_ocnt = r_ocnt; n_icnt = r_icnt; n_tcnt = r_tcnt;
                    n_lp0 = r_lp0; n_lp1 = r_lp1; n_lp2 = r_lp2;
                    o_code = mfpp_pkg::CODE_ERR; o_end = 1'b1;
                    o_outer = '0; o_inner = '0; o_item = '0; o_word = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= mfpp_pkg::PH_IDLE; r_pos <= '0; r_acc <= '0; r_word <= '0;
            r_ocnt <= '0; r_icnt <= '0; r_tcnt <= '0;
            r_lp0 <= '0; r_lp1 <= '0; r_lp2 <= '0;
        end else begin
            r_phase <= n_phase; r_pos <= n_pos; r_acc <= n_acc; r_word <= n_word;
            r_ocnt <= n_ocnt; r_icnt <= n_icnt; r_tcnt <= n_tcnt;
            r_lp0 <= n_lp0; r_lp1 <= n_lp1; r_lp2 <= n_lp2;
        end
    end
endmodule

// File: rtl/mfpp_resq.sv
// Result queue between the walker and the result port.
// Depends on nothing but its width and depth parameters.
module mfpp_resq #(
    parameter int W = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic         o_empty,
    output logic         o_almost_full,
    output logic [W-1:0] o_data
);
    localparam int AW = $clog2(DEPTH);
    logic [W-1:0] r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          do_pop;

    assign o_empty = r_cnt == '0;
    // one slot kept back so an item accepted now can still land
    assign o_almost_full = r_cnt >= (AW+1)'(DEPTH - 1);
    assign do_pop = i_pop && !o_empty;
    assign o_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (do_pop) r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(do_pop);
        end
    end
endmodule

// File: rtl/mocap_frame_packet_parser_unit.sv
// Motion-capture frame packet parser: one payload byte per cycle in while
// full is low, one tagged field result per completed field out.
// Input is a queue-style push/full channel; results leave through empty/pop.
// Configuration (version major at 0x0, minor at 0x4) through an APB-style port.
// Bytes are taken whenever full is low: one per cycle while results are popped.
// A result shows on the result ports once it heads the result queue.
// Each result is written into a four-entry queue; full rises when only one
// slot remains, so a stalled receiver holds the input back without loss.
// Reset puts the parser in idle awaiting a frame start byte, clears the queue
// and sets version 3.0. Bytes while idle without frame_start are dropped.
// Depends on mfpp_pkg, mfpp_walker, mfpp_resq.
module mocap_frame_packet_parser_unit #(
    parameter int INDEX_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_frame_start,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [5:0]  o_field_code,
    output logic [63:0] o_field_value,
    output logic [15:0] o_outer_index,
    output logic [15:0] o_inner_index,
    output logic [15:0] o_item_index,
    output logic [3:0]  o_word_index,
    output logic        o_frame_end,
    output logic        o_model_update,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int RW = 6 + 64 + 16*3 + 4 + 2;

    logic [7:0] r_major, r_minor;
    logic       acc, res_v, ct, mc, fe;
    logic [5:0] code;
    logic [63:0] val;
    logic [15:0] oi, ii, ti;
    logic [3:0]  wi;
    logic [RW-1:0] qout;

    assign pready = 1'b1;
    assign acc = i_push && !o_full;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_major <= 8'd3; r_minor <= 8'd0;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == mfpp_pkg::REG_MINOR[0]) r_minor <= pwdata[7:0];
            else r_major <= pwdata[7:0];
        end
    end
    assign ct = paddr[2] == mfpp_pkg::REG_MAJOR[0];
    assign prdata = {24'd0, ct ? r_major : r_minor};

    mfpp_walker #(.INDEX_WIDTH(INDEX_WIDTH)) u_walk (
        .i_clk, .i_rst_n, .i_major(r_major), .i_minor(r_minor),
        .i_valid(acc), .i_byte(i_data_byte), .i_start(i_frame_start),
        .o_res_valid(res_v), .o_code(code), .o_value(val), .o_outer(oi),
        .o_inner(ii), .o_item(ti), .o_word(wi), .o_end(fe), .o_models(mc)
    );

    mfpp_resq #(.W(RW), .DEPTH(mfpp_pkg::QDEPTH)) u_q (
        .i_clk, .i_rst_n, .i_push(res_v),
        .i_data({code, val, oi, ii, ti, wi, fe, mc}),
        .i_pop, .o_empty, .o_almost_full(o_full), .o_data(qout)
    );

    assign {o_field_code, o_field_value, o_outer_index, o_inner_index,
            o_item_index, o_word_index, o_frame_end, o_model_update} = qout;
endmodule

// File: verif/mocap_frame_packet_parser_unit_tb.sv
// Self-checking testbench for mocap_frame_packet_parser_unit: builds frame payloads
// per protocol version and checks every field result against an in-bench parser.
// Depends on mfpp_pkg and the RTL of the parser unit.
module mocap_frame_packet_parser_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        bit [5:0]  code;
        bit [63:0] value;
        bit [15:0] outer_idx;
        bit [15:0] inner_idx;
        bit [15:0] item_idx;
        bit [3:0]  word_idx;
        bit        frame_end;
        bit        model_update;
    } t_field_res;

    localparam bit [5:0] FC_MARKERSET_NAME = 6'd2;
    localparam bit [5:0] FC_OTHER_COUNT    = 6'd5;
    localparam bit [5:0] FC_BODY_WORD      = 6'd8;
    localparam bit [5:0] FC_BODY_PARAMS    = 6'd9;
    localparam bit [5:0] FC_SKEL_COUNT     = 6'd10;
    localparam bit [5:0] FC_SKEL_ID        = 6'd11;
    localparam bit [5:0] FC_BONE_WORD      = 6'd13;
    localparam bit [5:0] FC_BONE_PARAMS    = 6'd14;
    localparam bit [5:0] FC_LABEL_COUNT    = 6'd15;
    localparam bit [5:0] FC_LABEL_WORD     = 6'd16;
    localparam bit [5:0] FC_LABEL_PARAMS   = 6'd17;
    localparam bit [5:0] FC_LABEL_RESID    = 6'd18;
    localparam bit [5:0] FC_PLATE_COUNT    = 6'd19;
    localparam bit [5:0] FC_DEVICE_COUNT   = 6'd24;
    localparam bit [5:0] FC_LATENCY        = 6'd29;
    localparam bit [5:0] FC_TIMECODE       = 6'd30;
    localparam bit [5:0] FC_TIMESTAMP      = 6'd31;
    localparam bit [5:0] FC_CAM_STAMP      = 6'd32;
    localparam bit [5:0] FC_OTHER_WORD     = 6'd6;
    localparam bit [5:0] FC_MARKER_COUNT   = 6'd3;
    localparam bit [5:0] FC_MARKER_WORD    = 6'd4;
    localparam bit [31:0] COUNT_LIMIT      = 32'h0001_0000;
    localparam int WATCHDOG_LIMIT          = 4000;
    localparam int unsigned PHASE_BYTES    = 136;

    // Field parser mirror: tracks the layout walk and queues expected results
    class mfpp_scoreboard;
        bit [7:0]  ver_major = 8'd3;
        bit [7:0]  ver_minor = 8'd0;
        bit [5:0]  phase = mfpp_pkg::PH_IDLE;
        int unsigned pos;
        bit [63:0] acc;
        bit [31:0] n_outer, n_inner, n_item;
        bit [31:0] lp [3];
        bit [3:0]  rec;
        t_field_res expected_fields [$];
        int errors;

        function bit ver(int unsigned m);
            return ver_major > 2 || (ver_major == 2 && ver_minor >= m);
        endfunction

        function void enter(bit [5:0] p);
            phase = p;
            rec = 0;
        endfunction

        function bit count_ok(bit [63:0] v, output bit [31:0] n);
            n = v[31] ? 32'd0 : v[31:0];
            return n <= COUNT_LIMIT;
        endfunction

        function int unsigned field_len(bit [5:0] c);
            case (c)
                FC_MARKERSET_NAME: return 1;
                FC_BODY_PARAMS, FC_BONE_PARAMS, FC_LABEL_PARAMS,
                mfpp_pkg::CODE_PRM: return 2;
                FC_TIMESTAMP: return ver(7) ? 8 : 4;
                6'd32, 6'd33, 6'd34: return 8;
                default: return 4;
            endcase
        endfunction

        // Layout tail once each section is exhausted
        function void after_devices();
            enter(ver_major < 3 ? FC_LATENCY : FC_TIMECODE);
        endfunction
        function void after_plates();
            if (ver(mfpp_pkg::DEVICE_MINOR)) enter(FC_DEVICE_COUNT); else after_devices();
        endfunction
        function void after_labeled();
            if (ver(9)) enter(FC_PLATE_COUNT); else after_plates();
        endfunction
        function void after_skeletons();
            if (ver(3)) enter(FC_LABEL_COUNT); else after_labeled();
        endfunction
        function void after_bodies();
            if (ver(1)) enter(FC_SKEL_COUNT); else after_skeletons();
        endfunction

        function void next_markerset();
            lp[0]++;
            enter(lp[0] >= n_outer ? FC_OTHER_COUNT : FC_MARKERSET_NAME);
        endfunction
        function void next_body();
            lp[0]++;
            if (lp[0] >= n_outer) after_bodies(); else enter(FC_BODY_WORD);
        endfunction
        function void next_skeleton();
            lp[0]++;
            if (lp[0] >= n_outer) after_skeletons(); else enter(FC_SKEL_ID);
        endfunction
        function void next_bone();
            lp[1]++;
            if (lp[1] >= n_inner) next_skeleton(); else enter(FC_BONE_WORD);
        endfunction
        function void next_labeled();
            lp[0]++;
            if (lp[0] >= n_outer) after_labeled(); else enter(FC_LABEL_WORD);
        endfunction
        function void group_done(bit [5:0] base);
            if (base == FC_PLATE_COUNT) after_plates(); else after_devices();
        endfunction
        function void next_entry(bit [5:0] base);
            lp[0]++;
            if (lp[0] >= n_outer) group_done(base); else enter(base + 6'd1);
        endfunction
        function void next_channel(bit [5:0] base);
            lp[1]++;
            if (lp[1] >= n_inner) next_entry(base); else enter(base + 6'd3);
        endfunction

        // Pose record of a body or bone: 8 or 9 words then optional params
        function void pose_word(bit [5:0] params_code);
            rec++;
            if (rec < (ver_major >= 2 ? 9 : 8)) return;
            rec = 0;
            if (ver(6)) enter(params_code);
            else if (params_code == FC_BODY_PARAMS) next_body();
            else next_bone();
        endfunction

        // Walk on after field c completed; returns 0 on an oversized count
        function bit walk(bit [5:0] c, bit [63:0] v);
            bit [31:0] n;
            case (c)
                6'd0: enter(6'd1);
                6'd1, FC_OTHER_COUNT, 6'd7, FC_SKEL_COUNT, FC_LABEL_COUNT,
                FC_PLATE_COUNT, FC_DEVICE_COUNT: begin
                    if (!count_ok(v, n)) return 0;
                    n_outer = n;
                    lp[0] = 0;
                    if (c == 6'd1) enter(n == 0 ? FC_OTHER_COUNT : FC_MARKERSET_NAME);
                    else if (c == FC_OTHER_COUNT) enter(n == 0 ? 6'd7 : FC_OTHER_WORD);
                    else if (n != 0) enter(c + 6'd1);
                    else if (c == 6'd7) after_bodies();
                    else if (c == FC_SKEL_COUNT) after_skeletons();
                    else if (c == FC_LABEL_COUNT) after_labeled();
                    else group_done(c);
                end
                FC_MARKERSET_NAME: if (v == 0) enter(FC_MARKER_COUNT);
                FC_MARKER_COUNT, 6'd12: begin
                    if (!count_ok(v, n)) return 0;
                    n_inner = n;
                    lp[1] = 0;
                    if (n != 0) enter(c + 6'd1);
                    else if (c == FC_MARKER_COUNT) next_markerset();
                    else next_skeleton();
                end
                FC_MARKER_WORD: begin
                    rec++;
                    if (rec >= 3) begin
                        rec = 0;
                        lp[1]++;
                        if (lp[1] >= n_inner) next_markerset();
                    end
                end
                FC_OTHER_WORD: begin
                    rec++;
                    if (rec >= 3) begin
                        rec = 0;
                        lp[0]++;
                        if (lp[0] >= n_outer) enter(6'd7);
                    end
                end
                FC_BODY_WORD: pose_word(FC_BODY_PARAMS);
                FC_BODY_PARAMS: next_body();
                FC_SKEL_ID: enter(6'd12);
                FC_BONE_WORD: pose_word(FC_BONE_PARAMS);
                FC_BONE_PARAMS: next_bone();
                FC_LABEL_WORD: begin
                    rec++;
                    if (rec >= 5) begin
                        rec = 0;
                        if (ver(6)) enter(FC_LABEL_PARAMS);
                        else if (ver_major >= 3) enter(FC_LABEL_RESID);
                        else next_labeled();
                    end
                end
                FC_LABEL_PARAMS: if (ver_major >= 3) enter(FC_LABEL_RESID); else next_labeled();
                FC_LABEL_RESID: next_labeled();
                6'd20, 6'd25: enter(c + 6'd1);
                6'd21, 6'd26: begin
                    if (!count_ok(v, n)) return 0;
                    n_inner = n;
                    lp[1] = 0;
                    if (n == 0) next_entry(c - 6'd2); else enter(c + 6'd1);
                end
                6'd22, 6'd27: begin
                    if (!count_ok(v, n)) return 0;
                    n_item = n;
                    lp[2] = 0;
                    if (n == 0) next_channel(c - 6'd3); else enter(c + 6'd1);
                end
                6'd23, 6'd28: begin
                    lp[2]++;
                    if (lp[2] >= n_item) next_channel(c - 6'd4);
                end
                FC_LATENCY: enter(FC_TIMECODE);
                FC_TIMECODE: if (rec == 0) rec = 1; else enter(FC_TIMESTAMP);
                FC_TIMESTAMP: enter(ver_major >= 3 ? FC_CAM_STAMP : mfpp_pkg::CODE_PRM);
                6'd32, 6'd33, 6'd34, mfpp_pkg::CODE_PRM: enter(c + 6'd1);
                default: enter(mfpp_pkg::PH_IDLE);
            endcase
            return 1;
        endfunction

        function void set_reg(bit [1:0] idx, bit [7:0] val);
            if (idx == mfpp_pkg::REG_MAJOR) ver_major = val;
            else if (idx == mfpp_pkg::REG_MINOR) ver_minor = val;
        endfunction

        function t_field_res error_res(bit [63:0] v);
            t_field_res r;
            r = '{default: 0};
            r.code = mfpp_pkg::CODE_ERR;
            r.value = v;
            r.frame_end = 1;
            return r;
        endfunction

        // One accepted payload byte
        function void note_byte(bit [7:0] b, bit start);
            t_field_res r;
            bit mid;
            bit [5:0] c;
            int unsigned loops;
            bit use_word;
            if (start) begin
                mid = phase != mfpp_pkg::PH_IDLE;
                enter(6'd0);
                n_outer = 0; n_inner = 0; n_item = 0;
                lp[0] = 0; lp[1] = 0; lp[2] = 0;
                acc = b;
                pos = 1;
                if (mid) expected_fields.push_back(error_res(64'd0));
                return;
            end
            if (phase == mfpp_pkg::PH_IDLE) return;
            acc |= 64'(b) << (8 * (pos & 7));
            pos++;
            c = phase;
            if (pos < field_len(c)) return;
            // index usage per field code
            case (c)
                6'd2, 6'd3, 6'd9, 6'd11, 6'd12, 6'd17, 6'd18,
                6'd20, 6'd21, 6'd25, 6'd26: loops = 1;
                6'd4, 6'd13, 6'd14, 6'd22, 6'd27: loops = 2;
                6'd23, 6'd28: loops = 3;
                6'd6, 6'd8, 6'd16: loops = 1;
                default: loops = 0;
            endcase
            use_word = c inside {6'd4, 6'd6, 6'd8, 6'd13, 6'd16, 6'd30};
            r = '{default: 0};
            r.code = c;
            r.value = acc;
            if (loops >= 1) r.outer_idx = lp[0][15:0];
            if (loops >= 2) r.inner_idx = lp[1][15:0];
            if (loops >= 3) r.item_idx = lp[2][15:0];
            if (use_word) r.word_idx = rec;
            r.frame_end = c == mfpp_pkg::CODE_END;
            r.model_update = c == mfpp_pkg::CODE_PRM &&
                             (acc[7:0] & mfpp_pkg::MODEL_UPDATE_MASK) != 0;
            acc = 0;
            pos = 0;
            if (!walk(c, r.value)) begin
                enter(mfpp_pkg::PH_IDLE);
                r = error_res(r.value);
            end
            expected_fields.push_back(r);
        endfunction

        // One popped result against the oldest expectation
        function void check_field(t_field_res got);
            t_field_res e;
            if (expected_fields.size() == 0) begin
                $display("%0t: unexpected result code %0d value %h", $time, got.code, got.value);
                errors++;
                return;
            end
            e = expected_fields.pop_front();
            if (got.code != e.code) begin
                $display("%0t: field_code exp %0d got %0d", $time, e.code, got.code);
                errors++;
            end
            if (got.value != e.value) begin
                $display("%0t: field_value exp %h got %h", $time, e.value, got.value);
                errors++;
            end
            if (got.outer_idx != e.outer_idx) begin
                $display("%0t: outer_index exp %0d got %0d", $time, e.outer_idx, got.outer_idx);
                errors++;
            end
            if (got.inner_idx != e.inner_idx) begin
                $display("%0t: inner_index exp %0d got %0d", $time, e.inner_idx, got.inner_idx);
                errors++;
            end
            if (got.item_idx != e.item_idx) begin
                $display("%0t: item_index exp %0d got %0d", $time, e.item_idx, got.item_idx);
                errors++;
            end
            if (got.word_idx != e.word_idx) begin
                $display("%0t: word_index exp %0d got %0d", $time, e.word_idx, got.word_idx);
                errors++;
            end
            if (got.frame_end != e.frame_end) begin
                $display("%0t: frame_end exp %0b got %0b", $time, e.frame_end, got.frame_end);
                errors++;
            end
            if (got.model_update != e.model_update) begin
                $display("%0t: model_update exp %0b got %0b", $time,
                         e.model_update, got.model_update);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_push = 1'b0;
    logic        o_full;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_frame_start = 1'b0;
    logic        o_empty;
    logic        i_pop = 1'b0;
    logic [5:0]  o_field_code;
    logic [63:0] o_field_value;
    logic [15:0] o_outer_index, o_inner_index, o_item_index;
    logic [3:0]  o_word_index;
    logic        o_frame_end, o_model_update;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    mfpp_scoreboard sb = new();
    int unsigned send_idle_pct, pop_stall_pct;
    int unsigned stall_cycles;
    int unsigned n_sent;
    bit [7:0]    frame_bytes [$];
    bit          frame_cut;
    bit [7:0]    gen_major = 8'd3, gen_minor = 8'd0;

    mocap_frame_packet_parser_unit u_dut (.*);

    always #10 i_clk = ~i_clk;

    // Receiver: pop decided at each falling edge
    always @(negedge i_clk) begin
        i_pop <= ($urandom_range(99) >= pop_stall_pct);
    end

    // Monitor: requests and results taken at the rising edge, plus watchdog
    always @(posedge i_clk) begin
        t_field_res got;
        if (i_rst_n) begin
            stall_cycles++;
            if (i_push && !o_full) begin
                sb.note_byte(i_data_byte, i_frame_start);
                stall_cycles = 0;
            end
            if (i_pop && !o_empty) begin
                got.code = o_field_code;
                got.value = o_field_value;
                got.outer_idx = o_outer_index;
                got.inner_idx = o_inner_index;
                got.item_idx = o_item_index;
                got.word_idx = o_word_index;
                got.frame_end = o_frame_end;
                got.model_update = o_model_update;
                sb.check_field(got);
                stall_cycles = 0;
            end
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired", $time);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Send one byte request, with random gaps ahead of it
    task automatic send_byte(bit [7:0] b, bit start);
        if ($urandom_range(99) < send_idle_pct) begin
            i_push <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_push <= 1'b1;
        i_data_byte <= b;
        i_frame_start <= start;
        do @(posedge i_clk); while (o_full);
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_push <= 1'b0;
        while (sb.expected_fields.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic apb_write(bit [1:0] idx, bit [7:0] val);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx[0], 2'b00};
        pwdata <= {24'($urandom_range(0, 32'hFF_FFFF)), val};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic set_version(bit [7:0] maj, bit [7:0] minr);
        drain();
        apb_write(mfpp_pkg::REG_MAJOR, maj);
        apb_write(mfpp_pkg::REG_MINOR, minr);
        gen_major = maj;
        gen_minor = minr;
    endtask

    function automatic bit gen_ver(int unsigned m);
        return gen_major > 2 || (gen_major == 2 && gen_minor >= m);
    endfunction

    function automatic void put_random(int unsigned nbytes);
        repeat (nbytes) frame_bytes.push_back($urandom_range(0, 255));
    endfunction

    function automatic void put_word(bit [31:0] w);
        for (int k = 0; k < 4; k++) frame_bytes.push_back(w[8*k +: 8]);
    endfunction

    // Count field: mostly small, sometimes negative, rarely oversized (cuts the frame)
    function automatic int unsigned put_count(int unsigned maxn);
        int unsigned r;
        r = $urandom_range(0, 59);
        if (r == 0) begin
            put_word(32'h0001_0001 + $urandom_range(0, 32'h7FFE_0000));
            frame_cut = 1;
            return 0;
        end
        if (r < 4) begin
            put_word({1'b1, 31'($urandom)});
            return 0;
        end
        r = $urandom_range(0, maxn);
        put_word(r);
        return r;
    endfunction

    function automatic void put_group();
        int unsigned n, ch, s;
        n = put_count(2);
        for (int e = 0; e < n && !frame_cut; e++) begin
            put_random(4);
            ch = put_count(2);
            for (int c = 0; c < ch && !frame_cut; c++) begin
                s = put_count(3);
                put_random(4 * s);
            end
        end
    endfunction

    // Well-formed frame for the current version, stopped early at an oversized count
    function automatic void build_frame();
        int unsigned n, m, pose;
        frame_bytes = {};
        frame_cut = 0;
        pose = (gen_major >= 2 ? 36 : 32) + (gen_ver(6) ? 2 : 0);
        put_random(4);
        n = put_count(2);
        for (int s = 0; s < n && !frame_cut; s++) begin
            repeat ($urandom_range(0, 3)) frame_bytes.push_back($urandom_range(1, 255));
            frame_bytes.push_back(8'd0);
            m = put_count(3);
            put_random(12 * m);
        end
        if (frame_cut) return;
        n = put_count(3);
        if (frame_cut) return;
        put_random(12 * n);
        n = put_count(2);
        if (frame_cut) return;
        put_random(pose * n);
        if (gen_ver(1)) begin
            n = put_count(2);
            for (int s = 0; s < n && !frame_cut; s++) begin
                put_random(4);
                m = put_count(2);
                put_random(pose * m);
            end
            if (frame_cut) return;
        end
        if (gen_ver(3)) begin
            n = put_count(2);
            if (frame_cut) return;
            put_random(n * (20 + (gen_ver(6) ? 2 : 0) + (gen_major >= 3 ? 4 : 0)));
        end
        if (gen_ver(9)) put_group();
        if (frame_cut) return;
        if (gen_ver(mfpp_pkg::DEVICE_MINOR)) put_group();
        if (frame_cut) return;
        if (gen_major < 3) put_random(4);
        put_random(8);
        put_random(gen_ver(7) ? 8 : 4);
        if (gen_major >= 3) put_random(24);
        put_random(2);
        put_random(4);
    endfunction

    task automatic send_frame();
        int unsigned len;
        build_frame();
        len = frame_bytes.size();
        // restart in mid-frame now and then
        if ($urandom_range(0, 9) == 0) len = $urandom_range(1, len - 1);
        for (int k = 0; k < len; k++) send_byte(frame_bytes[k], k == 0);
        // noise with random frame starts
        if ($urandom_range(0, 14) == 0)
            repeat ($urandom_range(3, 8)) send_byte($urandom_range(0, 255), $urandom_range(0, 1));
    endtask

    task automatic send_word(bit [31:0] w);
        for (int k = 0; k < 4; k++) send_byte(w[8*k +: 8], 1'b0);
    endtask

    initial begin
        bit [7:0] versions [11][2];
        versions = '{'{8'd3, 8'd0}, '{8'd2, 8'd0}, '{8'd2, 8'd11}, '{8'd2, 8'd6},
                     '{8'd1, 8'd0}, '{8'd0, 8'd0}, '{8'd255, 8'd255}, '{8'd2, 8'd3},
                     '{8'd2, 8'd9}, '{8'd2, 8'd7}, '{8'd3, 8'd0}};
        send_idle_pct = 0;
        pop_stall_pct = 0;
        n_sent = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: idle byte, frame number of ones, negative count, oversized count
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_word(32'hFFFF_FFFF);
        send_word(32'hFFFF_FFFF);
        send_word(32'h0001_0001);
        send_byte(8'h00, 1'b0);
        // restart while mid-frame, then a count at exactly the limit and restart again
        send_byte(8'h00, 1'b1);
        send_word(32'h0000_0000);
        send_byte(8'h5A, 1'b1);
        send_word(32'h0000_0001);
        send_word(32'h0000_0001);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_word(32'h0001_0000);
        send_byte(8'h00, 1'b1);

        // Random frames over a run of versions and idling patterns
        for (int p = 0; p < 11; p++) begin
            set_version(versions[p][0], versions[p][1]);
            case (p % 4)
                0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
                1: begin send_idle_pct = 58; pop_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  pop_stall_pct = 58; end
                default: begin send_idle_pct = 17; pop_stall_pct = 17; end
            endcase
            while (n_sent < (p + 1) * PHASE_BYTES) begin
                send_frame();
                if (p == 2 && n_sent < (p + 1) * PHASE_BYTES) drain();
            end
        end

        drain();
        if (sb.errors == 0 && sb.expected_fields.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/mfpp_pkg.sv
rtl/mfpp_walker.sv
rtl/mfpp_resq.sv
rtl/mocap_frame_packet_parser_unit.sv
verif/mocap_frame_packet_parser_unit_tb.sv
